>>> rtl/core/rq_pkg.sv
// ----------------------------------------------------------------------------
// rq_pkg
// Shared sizes, codes and payload types of the request queue.
// ----------------------------------------------------------------------------
package rq_pkg;

	localparam int SLOTS       = 1024;
	localparam int HANDLE_BITS = 16;
	localparam int SIZE_BITS   = 32;
	localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int CAP_W       = 11;
	localparam int IDX_W       = 1;

	// busy bits packed in rows
	localparam int BW    = 32;
	localparam int BIT_W = 5;
	localparam int BROWS = (SLOTS + BW - 1) / BW;
	localparam int ROW_W = (BROWS > 1) ? $clog2(BROWS) : 1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_TAKE   = 1'b1;
	localparam logic POL_FIFO    = 1'b0;
	localparam logic POL_SMALL   = 1'b1;

	localparam logic [IDX_W-1:0] REG_POLICY   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_CAPACITY = IDX_W'(1);

	typedef struct packed {
		logic                   kind;
		logic [HANDLE_BITS-1:0] handle;
		logic [SIZE_BITS-1:0]   req_size;
	} req_t;

	typedef struct packed {
		logic                   ok;
		logic [SLOT_W-1:0]      slot;
		logic [HANDLE_BITS-1:0] out_handle;
		logic [SIZE_BITS-1:0]   out_size;
		logic [CNT_W-1:0]       occupancy;
	} rsp_t;

	// ring / heap entry: key carried with the slot
	typedef struct packed {
		logic [SIZE_BITS-1:0] size;
		logic [SLOT_W-1:0]    slot;
	} ord_t;

	typedef struct packed {
		logic [HANDLE_BITS-1:0] handle;
		logic [SIZE_BITS-1:0]   size;
	} dat_t;

	function automatic logic [ROW_W-1:0] row_of(input logic [SLOT_W-1:0] s);
		return ROW_W'(s >> BIT_W);
	endfunction

	function automatic logic [BIT_W-1:0] bit_of(input logic [SLOT_W-1:0] s);
		return BIT_W'(s);
	endfunction

endpackage

>>> rtl/core/rq_ram.sv
// ----------------------------------------------------------------------------
// rq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/request_queue_fifo_or_shortest_first.sv
// ----------------------------------------------------------------------------
// request_queue_fifo_or_shortest_first
// Request buffer ordered first in first out or smallest size first.
// ----------------------------------------------------------------------------
// Steps, start to done: a refused insert or an empty take is answered from idle; an
//   insert reads and claims a free busy bit, in heap order then sifts up with one
//   parent compare per level; every full busy row skipped adds a reread (32 slots a row).
// A take in FIFO order reads the ring head, then frees the slot's busy bit; in heap order
//   it reads root and last entry, sifts down level by level, then frees the busy bit.
// One request at a time; busy is high until the result strobe. No stall on done.
// Reset and every policy change run a clearing pass over all 32 busy rows
//   with busy high.
module request_queue_fifo_or_shortest_first (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  rq_pkg::req_t                request,
	output logic                        busy,
	output logic                        done,
	output rq_pkg::rsp_t                result,
	input  logic                        cfg_we,
	input  logic [rq_pkg::IDX_W-1:0]    cfg_index,
	input  logic [rq_pkg::CAP_W-1:0]    cfg_data
);
	import rq_pkg::*;

	localparam int LW = SLOT_W + 2;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_A_RD  = 4'd2;
	localparam logic [3:0] S_A_CHK = 4'd3;
	localparam logic [3:0] S_U_RD  = 4'd4;
	localparam logic [3:0] S_U_CHK = 4'd5;
	localparam logic [3:0] S_F_RD  = 4'd6;
	localparam logic [3:0] S_F_GET = 4'd7;
	localparam logic [3:0] S_H_RD0 = 4'd8;
	localparam logic [3:0] S_H_RD1 = 4'd9;
	localparam logic [3:0] S_H_RD2 = 4'd10;
	localparam logic [3:0] S_D_L   = 4'd11;
	localparam logic [3:0] S_D_R   = 4'd12;
	localparam logic [3:0] S_D_C   = 4'd13;
	localparam logic [3:0] S_FR_RD = 4'd14;
	localparam logic [3:0] S_FR_WR = 4'd15;

	logic [3:0]             state_q;
	logic                   policy_q;
	logic [CAP_W-1:0]       cap_q;
	logic [SLOT_W-1:0]      head_q, tail_q, cursor_q, pos_q, slot_q;
	logic [CNT_W-1:0]       count_q;
	logic [ROW_W-1:0]       row_q;
	logic                   first_q, has_right_q, done_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [SIZE_BITS-1:0]   size_q;
	ord_t                   carry_q, left_q;
	rsp_t                   out_q;

	logic                   b_we;
	logic [ROW_W-1:0]       b_waddr, b_raddr;
	logic [BW-1:0]          b_wdata, b_rdata;
	logic                   d_we;
	logic [SLOT_W-1:0]      d_waddr, d_raddr;
	dat_t                   d_wdata, d_rdata;
	logic                   o_we;
	logic [SLOT_W-1:0]      o_waddr, o_raddr;
	ord_t                   o_wdata, o_rdata;

	logic [BW-1:0]          free_bits;
	logic                   any_free;
	logic [BIT_W-1:0]       found_bit;
	logic [SLOT_W-1:0]      found_slot;
	logic                   full;
	logic [LW-1:0]          left_idx, right_idx, n_ext;
	logic [SLOT_W-1:0]      parent_idx, best_idx;
	ord_t                   new_ent, best_ent;
	logic                   left_lt, right_lt, moved, up_lt;

	rq_ram #(.WIDTH(BW), .DEPTH(BROWS)) u_busy (
		.clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.raddr(b_raddr), .rdata(b_rdata)
	);

	rq_ram #(.WIDTH($bits(dat_t)), .DEPTH(SLOTS)) u_data (
		.clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	rq_ram #(.WIDTH($bits(ord_t)), .DEPTH(SLOTS)) u_order (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
		.raddr(o_raddr), .rdata(o_rdata)
	);

	assign full = ({1'b0, count_q} >= ((cap_q > CAP_W'(SLOTS)) ?
		(CNT_W + 1)'(SLOTS) : (CNT_W + 1)'(cap_q)));

	// free-slot search in one busy row
	always_comb begin
		for (int i = 0; i < BW; i++) begin
			free_bits[i] = !b_rdata[i]
				&& !(first_q && (BIT_W'(i) < bit_of(cursor_q)))
				&& ((int'(row_q) * BW + i) < SLOTS);
		end
		any_free  = |free_bits;
		found_bit = '0;
		for (int i = BW - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				found_bit = BIT_W'(i);
			end
		end
		found_slot = SLOT_W'({row_q, found_bit});
	end

	assign new_ent    = '{size: size_q, slot: slot_q};
	assign parent_idx = SLOT_W'((pos_q - SLOT_W'(1)) >> 1);
	assign up_lt      = size_q < o_rdata.size;
	assign left_idx   = {1'b0, pos_q, 1'b1};
	assign right_idx  = left_idx + LW'(1);
	assign n_ext      = LW'(count_q);

	always_comb begin
		left_lt  = left_q.size < carry_q.size;
		best_ent = left_lt ? left_q : carry_q;
		best_idx = left_lt ? SLOT_W'(left_idx) : pos_q;
		right_lt = has_right_q && (o_rdata.size < best_ent.size);
		if (right_lt) begin
			best_ent = o_rdata;
			best_idx = SLOT_W'(right_idx);
		end
		moved = left_lt || right_lt;
	end

	always_comb begin
		b_we    = 1'b0;
		b_waddr = row_q;
		b_wdata = '0;
		b_raddr = row_q;
		d_we    = 1'b0;
		d_waddr = found_slot;
		d_wdata = '{handle: handle_q, size: size_q};
		d_raddr = slot_q;
		o_we    = 1'b0;
		o_waddr = pos_q;
		o_wdata = carry_q;
		o_raddr = pos_q;
		unique case (state_q)
			S_CLEAR: begin
				b_we = 1'b1;
			end
			S_A_CHK: begin
				if (any_free) begin
					b_we    = 1'b1;
					b_wdata = b_rdata | (BW'(1) << found_bit);
					d_we    = 1'b1;
					if (policy_q == POL_FIFO) begin
						o_we    = 1'b1;
						o_waddr = tail_q;
						o_wdata = '{size: size_q, slot: found_slot};
					end
				end
			end
			S_U_RD: begin
				if (pos_q == '0) begin
					o_we    = 1'b1;
					o_wdata = new_ent;
				end else begin
					o_raddr = parent_idx;
				end
			end
			S_U_CHK: begin
				o_we    = 1'b1;
				o_wdata = up_lt ? o_rdata : new_ent;
			end
			S_F_RD: begin
				o_raddr = head_q;
			end
			S_H_RD0: begin
				o_raddr = '0;
			end
			S_H_RD1: begin
				o_raddr = SLOT_W'(count_q - CNT_W'(1));
			end
			S_D_L: begin
				if (left_idx >= n_ext) begin
					o_we = 1'b1;
				end else begin
					o_raddr = SLOT_W'(left_idx);
				end
			end
			S_D_R: begin
				o_raddr = SLOT_W'(right_idx);
			end
			S_D_C: begin
				o_we    = 1'b1;
				o_wdata = best_ent;
			end
			S_FR_RD: begin
				b_raddr = row_of(slot_q);
			end
			S_FR_WR: begin
				b_we    = 1'b1;
				b_waddr = row_of(slot_q);
				b_wdata = b_rdata & ~(BW'(1) << bit_of(slot_q));
			end
			default: begin
				b_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			row_q       <= '0;
			policy_q    <= POL_FIFO;
			cap_q       <= CAP_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			cursor_q    <= '0;
			first_q     <= 1'b0;
			has_right_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (row_q == ROW_W'(BROWS - 1)) begin
						row_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				S_IDLE: begin
					if (start) begin
						handle_q <= request.handle;
						size_q   <= request.req_size;
						if (request.kind == KIND_INSERT) begin
							if (full) begin
								done_q <= 1'b1;
								out_q  <= '{ok: 1'b0, slot: '0, out_handle: '0,
									out_size: '0, occupancy: count_q};
							end else begin
								row_q   <= row_of(cursor_q);
								first_q <= 1'b1;
								state_q <= S_A_RD;
							end
						end else if (count_q == '0) begin
							done_q <= 1'b1;
							out_q  <= '{ok: 1'b0, slot: '0, out_handle: '0,
								out_size: '0, occupancy: count_q};
						end else begin
							state_q <= (policy_q == POL_FIFO) ? S_F_RD : S_H_RD0;
						end
					end
				end
				S_A_RD: begin
					state_q <= S_A_CHK;
				end
				S_A_CHK: begin
					if (any_free) begin
						cursor_q <= found_slot;
						slot_q   <= found_slot;
						count_q  <= count_q + CNT_W'(1);
						if (policy_q == POL_FIFO) begin
							tail_q  <= (tail_q == SLOT_W'(SLOTS - 1)) ? '0 :
								tail_q + SLOT_W'(1);
							done_q  <= 1'b1;
							out_q   <= '{ok: 1'b1, slot: found_slot, out_handle: '0,
								out_size: '0, occupancy: count_q + CNT_W'(1)};
							state_q <= S_IDLE;
						end else begin
							pos_q   <= SLOT_W'(count_q);
							state_q <= S_U_RD;
						end
					end else begin
						row_q   <= (row_q == ROW_W'(BROWS - 1)) ? '0 : row_q + ROW_W'(1);
						first_q <= 1'b0;
						state_q <= S_A_RD;
					end
				end
				S_U_RD: begin
					if (pos_q == '0) begin
						done_q  <= 1'b1;
						out_q   <= '{ok: 1'b1, slot: slot_q, out_handle: '0,
							out_size: '0, occupancy: count_q};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_U_CHK;
					end
				end
				S_U_CHK: begin
					if (up_lt) begin
						pos_q   <= parent_idx;
						state_q <= S_U_RD;
					end else begin
						done_q  <= 1'b1;
						out_q   <= '{ok: 1'b1, slot: slot_q, out_handle: '0,
							out_size: '0, occupancy: count_q};
						state_q <= S_IDLE;
					end
				end
				S_F_RD: begin
					state_q <= S_F_GET;
				end
				S_F_GET: begin
					slot_q  <= o_rdata.slot;
					head_q  <= (head_q == SLOT_W'(SLOTS - 1)) ? '0 : head_q + SLOT_W'(1);
					count_q <= count_q - CNT_W'(1);
					state_q <= S_FR_RD;
				end
				S_H_RD0: begin
					state_q <= S_H_RD1;
				end
				S_H_RD1: begin
					slot_q  <= o_rdata.slot;
					state_q <= S_H_RD2;
				end
				S_H_RD2: begin
					carry_q <= o_rdata;
					count_q <= count_q - CNT_W'(1);
					pos_q   <= '0;
					state_q <= (count_q == CNT_W'(1)) ? S_FR_RD : S_D_L;
				end
				S_D_L: begin
					has_right_q <= right_idx < n_ext;
					state_q     <= (left_idx >= n_ext) ? S_FR_RD : S_D_R;
				end
				S_D_R: begin
					left_q  <= o_rdata;
					state_q <= S_D_C;
				end
				S_D_C: begin
					if (moved) begin
						pos_q   <= best_idx;
						state_q <= S_D_L;
					end else begin
						state_q <= S_FR_RD;
					end
				end
				S_FR_RD: begin
					state_q <= S_FR_WR;
				end
				S_FR_WR: begin
					done_q  <= 1'b1;
					out_q   <= '{ok: 1'b1, slot: slot_q, out_handle: d_rdata.handle,
						out_size: d_rdata.size, occupancy: count_q};
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (cfg_we) begin
				unique case (cfg_index)
					REG_POLICY: begin
						if (cfg_data[0] != policy_q) begin
							policy_q <= cfg_data[0];
							head_q   <= '0;
							tail_q   <= '0;
							count_q  <= '0;
							row_q    <= '0;
							state_q  <= S_CLEAR;
						end
					end
					REG_CAPACITY: begin
						cap_q <= cfg_data;
					end
					default: begin
						cap_q <= cap_q;
					end
				endcase
			end
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = out_q;

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.occupancy <= CNT_W'(SLOTS)))
		else $error("occupancy above slot count");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.ok) |->
			(result.slot == '0 && result.out_handle == '0 && result.out_size == '0))
		else $error("failed request carries nonzero payload");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("held count above slot count");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted request neither started nor answered");

endmodule

>>> verif/tb_request_queue_fifo_or_shortest_first.sv
// ----------------------------------------------------------------------------
// tb_request_queue_fifo_or_shortest_first
// Drives insert and take requests into the request queue under both ordering
// rules and several capacities, predicts every result with an in-bench model
// of the slot store, ring and min-heap, and compares each strobed result.
// ----------------------------------------------------------------------------
class rq_scoreboard;
	logic pol;
	int unsigned cap;
	bit busy_slot[rq_pkg::SLOTS];
	logic [rq_pkg::HANDLE_BITS-1:0] hnd[rq_pkg::SLOTS];
	logic [rq_pkg::SIZE_BITS-1:0] sz[rq_pkg::SLOTS];
	int unsigned ring[rq_pkg::SLOTS];
	int unsigned heap[rq_pkg::SLOTS];
	int unsigned head, tail, held, cursor;
	rq_pkg::rsp_t pending[$];
	int errors;
	int checked;

	function new();
		pol = rq_pkg::POL_FIFO;
		cap = 1024;
		head = 0; tail = 0; held = 0; cursor = 0;
		errors = 0; checked = 0;
		foreach (busy_slot[i]) busy_slot[i] = 0;
	endfunction

	function void empty_out();
		foreach (busy_slot[i]) busy_slot[i] = 0;
		head = 0; tail = 0; held = 0;
	endfunction

	function void write_reg(logic [rq_pkg::IDX_W-1:0] idx, logic [rq_pkg::CAP_W-1:0] d);
		if (idx == rq_pkg::REG_POLICY) begin
			if (d[0] != pol) empty_out();
			pol = d[0];
		end else begin
			cap = 32'(d);
		end
	endfunction

	function void swap_at(int unsigned a, int unsigned b);
		int unsigned t;
		t = heap[a]; heap[a] = heap[b]; heap[b] = t;
	endfunction

	function void note_request(rq_pkg::req_t r);
		rq_pkg::rsp_t e;
		int unsigned lim, s, p, l, rt, best, n;
		e = '0;
		lim = (cap < rq_pkg::SLOTS) ? cap : rq_pkg::SLOTS;
		if (r.kind == rq_pkg::KIND_INSERT) begin
			if (held < lim) begin
				n = 0;
				while (n < rq_pkg::SLOTS && busy_slot[cursor]) begin
					cursor = (cursor + 1) % rq_pkg::SLOTS;
					n++;
				end
				if (!busy_slot[cursor]) begin
					s = cursor;
					busy_slot[s] = 1;
					hnd[s] = r.handle;
					sz[s] = r.req_size;
					if (pol == rq_pkg::POL_FIFO) begin
						ring[tail] = s;
						tail = (tail + 1) % rq_pkg::SLOTS;
					end else begin
						heap[held] = s;
						p = held;
						while (p > 0 && sz[heap[p]] < sz[heap[(p - 1) / 2]]) begin
							swap_at(p, (p - 1) / 2);
							p = (p - 1) / 2;
						end
					end
					held++;
					e.ok = 1'b1;
					e.slot = rq_pkg::SLOT_W'(s);
				end
			end
		end else if (held > 0) begin
			if (pol == rq_pkg::POL_FIFO) begin
				s = ring[head];
				head = (head + 1) % rq_pkg::SLOTS;
				held--;
			end else begin
				s = heap[0];
				heap[0] = heap[held - 1];
				held--;
				p = 0;
				forever begin
					l = 2 * p + 1; rt = 2 * p + 2; best = p;
					if (l < held && sz[heap[l]] < sz[heap[best]]) best = l;
					if (rt < held && sz[heap[rt]] < sz[heap[best]]) best = rt;
					if (best == p) break;
					swap_at(p, best);
					p = best;
				end
			end
			busy_slot[s] = 0;
			e.ok = 1'b1;
			e.slot = rq_pkg::SLOT_W'(s);
			e.out_handle = hnd[s];
			e.out_size = sz[s];
		end
		e.occupancy = rq_pkg::CNT_W'(held);
		pending.push_back(e);
	endfunction

	function void check_result(rq_pkg::rsp_t got);
		rq_pkg::rsp_t e;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("unexpected result %p", got);
			return;
		end
		e = pending.pop_front();
		checked++;
		if (got !== e) begin
			errors++;
			if (errors <= 10) begin
				$display("mismatch: exp ok=%0d slot=%0d h=%0h sz=%0h occ=%0d",
					e.ok, e.slot, e.out_handle, e.out_size, e.occupancy);
				$display("          got ok=%0d slot=%0d h=%0h sz=%0h occ=%0d",
					got.ok, got.slot, got.out_handle, got.out_size, got.occupancy);
			end
		end
	endfunction
endclass

module tb_request_queue_fifo_or_shortest_first;
	timeunit 1ns;
	timeprecision 1ps;

	import rq_pkg::*;

	localparam int LIMIT = 3000000;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	req_t request = '0;
	logic busy, done;
	rsp_t result;
	logic cfg_we = 0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CAP_W-1:0] cfg_data = '0;

	rq_scoreboard sb;
	int cycles = 0;
	int n_ins = 0, n_take = 0;
	bit calm = 0;

	request_queue_fifo_or_shortest_first i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .request(request),
		.busy(busy), .done(done), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (done) sb.check_result(result);
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// start stays high between back-to-back requests; it drops only for a gap or a drain
	task automatic idle_gap();
		if (!calm && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic send(logic k, logic [15:0] h, logic [31:0] s);
		req_t r;
		idle_gap();
		r.kind = k; r.handle = h; r.req_size = s;
		start <= 1;
		request <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(r);
		if (k == KIND_INSERT) n_ins++; else n_take++;
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_cfg(logic [IDX_W-1:0] idx, logic [CAP_W-1:0] d);
		drain();
		cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		sb.write_reg(idx, d);
		cfg_we <= 0;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic rand_item(int unsigned take_pct, int unsigned size_max);
		logic [31:0] s;
		s = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(0, size_max);
		send(($urandom_range(0, 99) < take_pct) ? KIND_TAKE : KIND_INSERT,
			16'($urandom()), s);
	endtask

	initial begin
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// directed
		send(KIND_TAKE, 16'hFFFF, '1);
		send(KIND_INSERT, 16'h0000, 32'h0);
		send(KIND_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
		send(KIND_INSERT, 16'h1234, 32'h5);
		send(KIND_TAKE, '0, '0);
		send(KIND_TAKE, '0, '0);
		send(KIND_TAKE, '0, '0);
		send(KIND_TAKE, '0, '0);
		write_cfg(REG_CAPACITY, 11'd1);
		send(KIND_INSERT, 16'hA5A5, 32'h7);
		send(KIND_INSERT, 16'h5A5A, 32'h8);
		write_cfg(REG_POLICY, 11'd1);
		write_cfg(REG_CAPACITY, 11'd0);
		send(KIND_INSERT, 16'h1, 32'h1);
		write_cfg(REG_CAPACITY, 11'd2047);
		send(KIND_INSERT, 16'h11, 32'd9);
		send(KIND_INSERT, 16'h22, 32'd3);
		send(KIND_INSERT, 16'h33, 32'd3);
		send(KIND_INSERT, 16'h44, 32'hFFFF_FFFF);
		send(KIND_INSERT, 16'h55, 32'd0);
		write_cfg(REG_CAPACITY, 11'd2);
		send(KIND_INSERT, 16'h66, 32'd1);
		send(KIND_TAKE, '0, '0);
		write_cfg(REG_POLICY, 11'd1);
		send(KIND_TAKE, '0, '0);
		write_cfg(REG_POLICY, 11'd0);
		send(KIND_TAKE, '0, '0);

		// random phases: policy, capacity, take share, key range
		write_cfg(REG_CAPACITY, 11'd6);
		repeat (150) rand_item(45, 15);
		write_cfg(REG_POLICY, 11'd1);
		repeat (200) rand_item(45, 15);
		drain();
		repeat (50) rand_item(40, 1000);
		write_cfg(REG_CAPACITY, 11'd1024);
		repeat (250) rand_item(35, 50);
		write_cfg(REG_CAPACITY, 11'd3);
		repeat (60) rand_item(40, 50);
		write_cfg(REG_POLICY, 11'd0);
		write_cfg(REG_CAPACITY, 11'd1100);
		repeat (200) rand_item(40, 50);
		write_cfg(REG_POLICY, 11'd1);
		write_cfg(REG_CAPACITY, 11'd40);
		calm = 1;
		repeat (200) rand_item(50, 7);

		drain();
		$display("covered %0d inserts and %0d takes, %0d results checked, both orderings",
			n_ins, n_take, sb.checked);
		$display("capacities from zero to above the slot count, policy flushes included");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
